@@ src/tcld_pkg.sv @@
// ----------------------------------------------------------------------------
// tcld_pkg
// Shared types and constants of the text command line decoder: result kinds,
// number parse phases, ASCII codes and the request/result structs that pass
// between the top level and the line parser.
// ----------------------------------------------------------------------------
package tcld_pkg;

  localparam int unsigned OUT_W = 32;

  // Configuration register indexes (byte address 4*index).
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  typedef enum logic [3:0] {
    KIND_PING    = 4'd0,
    KIND_SAVE    = 4'd1,
    KIND_STATE   = 4'd2,
    KIND_MIX     = 4'd3,
    KIND_MANUAL  = 4'd4,
    KIND_ZERO    = 4'd5,
    KIND_PARAM   = 4'd6,
    KIND_RESET   = 4'd7,
    KIND_VISION  = 4'd8,
    KIND_HEART   = 4'd9,
    KIND_IGNORED = 4'd10,
    KIND_LINK    = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Command letters.
  localparam logic [7:0] CMD_STATE  = "T";
  localparam logic [7:0] CMD_MIX    = "X";
  localparam logic [7:0] CMD_MANUAL = "V";
  localparam logic [7:0] CMD_ZERO   = "Z";
  localparam logic [7:0] CMD_PARAM  = "P";
  localparam logic [7:0] CMD_RESET  = "R";
  localparam logic [7:0] CMD_VISION = "C";
  localparam logic [7:0] CMD_HEART  = "H";

  localparam logic [31:0] WORD_PING = "PING";
  localparam logic [31:0] WORD_SAVE = "SAVE";

  localparam logic [OUT_W-1:0] VISION_ARG2_DEFAULT = 32'd24;
  localparam logic [OUT_W-1:0] VISION_ARG3_DEFAULT = 32'd18;

  // Character p of a four-letter keyword, first letter in the top byte.
  function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] p);
    return w[{~p, 3'b000} +: 8];
  endfunction

  typedef struct packed {
    logic       en;
    logic [7:0] ch;
    logic       fe;
  } line_req_t;

  typedef struct packed {
    logic                       valid;
    kind_e                      kind;
    logic [3:0][OUT_W-1:0]      args;
  } line_res_t;

endpackage

@@ src/tcld_line.sv @@
// ----------------------------------------------------------------------------
// tcld_line
// Per-character line parser: keyword prefix match, first letter capture and
// incremental signed decimal list parsing. Closes a line on request and
// reports the decoded command in the same cycle.
// ----------------------------------------------------------------------------
module tcld_line #(
  parameter int unsigned MAX_ARGS = 6,
  parameter int unsigned ARG_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcld_pkg::line_req_t req_i,
  output tcld_pkg::line_res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_ARGS + 1);
  localparam int unsigned OW   = tcld_pkg::OUT_W;

  logic [2:0]               pos_q, pos_d;
  logic [7:0]               first_q, first_d;
  logic [1:0]               pm_q, pm_d;
  logic                     args_en_q, args_en_d;
  tcld_pkg::phase_e         phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic [ARG_BITS-1:0]      acc_q, acc_d;
  logic                     sat_q, sat_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [3:0][OW-1:0]       store_q, store_d;
  logic                     nonblank_q, nonblank_d;

  // State after the character has been added.
  logic [2:0]               a_pos;
  logic [7:0]               a_first;
  logic [1:0]               a_pm;
  logic                     a_args_en;
  tcld_pkg::phase_e         a_phase;
  logic                     a_neg;
  logic [ARG_BITS-1:0]      a_acc;
  logic                     a_sat;
  logic [CntW-1:0]          a_cnt;
  logic [3:0][OW-1:0]       a_store;
  logic                     a_nonblank;

  logic [7:0]               ch;
  logic                     is_term, closing, digit, space;
  logic [3:0]               dval;
  logic [ARG_BITS-1:0]      lim;
  logic [ARG_BITS+3:0]      acc10;
  logic                     ovf;
  logic [ARG_BITS-1:0]      feed_acc;
  logic                     feed_sat;
  logic [ARG_BITS+OW-1:0]   acc_ext, a_acc_ext;
  logic [OW-1:0]            push_v, close_v;
  logic [3:0][OW-1:0]       c_store;
  logic [CntW-1:0]          c_cnt;
  tcld_pkg::kind_e          kind;
  logic                     show;
  logic [3:0][OW-1:0]       args;

  assign ch      = req_i.ch;
  assign is_term = (ch == tcld_pkg::CH_NUL) || (ch == tcld_pkg::CH_LF);
  assign closing = is_term || req_i.fe;
  assign digit   = (ch >= tcld_pkg::CH_ZERO) && (ch <= tcld_pkg::CH_NINE);
  assign space   = (ch == tcld_pkg::CH_SPACE) ||
                   ((ch >= tcld_pkg::CH_TAB) && (ch <= tcld_pkg::CH_CR));
  assign dval    = ch[3:0];

  // Saturating digit accumulate: overflow when acc*10 + d exceeds the limit.
  assign lim   = {1'b1, {(ARG_BITS-1){1'b0}}} - ARG_BITS'(!neg_q);
  assign acc10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (ARG_BITS+4)'(dval);
  assign ovf   = acc10 > {4'b0, lim};
  always_comb begin
    feed_acc = acc_q;
    feed_sat = sat_q;
    if (!sat_q) begin
      if (ovf) begin
        feed_sat = 1'b1;
        feed_acc = lim;
      end else begin
        feed_acc = acc10[ARG_BITS-1:0];
      end
    end
  end

  assign acc_ext   = {{OW{1'b0}}, acc_q};
  assign a_acc_ext = {{OW{1'b0}}, a_acc};
  assign push_v    = neg_q ? (OW'(0) - acc_ext[OW-1:0]) : acc_ext[OW-1:0];
  assign close_v   = a_neg ? (OW'(0) - a_acc_ext[OW-1:0]) : a_acc_ext[OW-1:0];

  // Add the character to the line.
  always_comb begin
    a_pos      = pos_q;
    a_first    = first_q;
    a_pm       = pm_q;
    a_args_en  = args_en_q;
    a_phase    = phase_q;
    a_neg      = neg_q;
    a_acc      = acc_q;
    a_sat      = sat_q;
    a_cnt      = cnt_q;
    a_store    = store_q;
    a_nonblank = nonblank_q;
    if (!is_term) begin
      if ((ch != tcld_pkg::CH_SPACE) && (ch != tcld_pkg::CH_CR)) begin
        a_nonblank = 1'b1;
      end
      if (pos_q == 3'd0) begin
        a_first = ch;
      end
      if (pos_q < 3'd4) begin
        if (ch != tcld_pkg::word_byte(tcld_pkg::WORD_PING, pos_q[1:0])) begin
          a_pm[0] = 1'b0;
        end
        if (ch != tcld_pkg::word_byte(tcld_pkg::WORD_SAVE, pos_q[1:0])) begin
          a_pm[1] = 1'b0;
        end
      end
      if ((pos_q == 3'd1) && (ch == tcld_pkg::CH_COMMA)) begin
        a_args_en = 1'b1;
      end
      if ((pos_q >= 3'd2) && args_en_q) begin
        case (phase_q)
          tcld_pkg::PH_BEFORE: begin
            if (space) begin
              a_phase = tcld_pkg::PH_BEFORE;
            end else if ((ch == tcld_pkg::CH_PLUS) || (ch == tcld_pkg::CH_MINUS)) begin
              a_neg   = (ch == tcld_pkg::CH_MINUS);
              a_phase = tcld_pkg::PH_SIGN;
            end else if (digit) begin
              a_acc   = feed_acc;
              a_sat   = feed_sat;
              a_phase = tcld_pkg::PH_DIGITS;
            end else begin
              a_phase = tcld_pkg::PH_DONE;
            end
          end
          tcld_pkg::PH_SIGN: begin
            if (digit) begin
              a_acc   = feed_acc;
              a_sat   = feed_sat;
              a_phase = tcld_pkg::PH_DIGITS;
            end else begin
              a_phase = tcld_pkg::PH_DONE;
            end
          end
          tcld_pkg::PH_DIGITS: begin
            if (digit) begin
              a_acc = feed_acc;
              a_sat = feed_sat;
            end else begin
              if (cnt_q < CntW'(4)) begin
                a_store[cnt_q[1:0]] = push_v;
              end
              a_cnt = cnt_q + CntW'(1);
              if ((ch == tcld_pkg::CH_COMMA) && (a_cnt < CntW'(MAX_ARGS))) begin
                a_neg   = 1'b0;
                a_acc   = '0;
                a_sat   = 1'b0;
                a_phase = tcld_pkg::PH_BEFORE;
              end else begin
                a_phase = tcld_pkg::PH_DONE;
              end
            end
          end
          default: begin
            a_phase = phase_q;
          end
        endcase
      end
      a_pos = (pos_q < 3'd7) ? pos_q + 3'd1 : 3'd7;
    end
  end

  // Close the line: flush a number still in progress, then decode.
  always_comb begin
    c_store = a_store;
    c_cnt   = a_cnt;
    if ((a_phase == tcld_pkg::PH_DIGITS) && a_args_en) begin
      if (a_cnt < CntW'(4)) begin
        c_store[a_cnt[1:0]] = close_v;
      end
      c_cnt = a_cnt + CntW'(1);
    end

    // Entries past the argument count were never written and hold zero.
    args = c_store;
    show = 1'b1;
    if ((a_pos >= 3'd4) && a_pm[0]) begin
      kind = tcld_pkg::KIND_PING;
      show = 1'b0;
    end else if ((a_pos >= 3'd4) && a_pm[1]) begin
      kind = tcld_pkg::KIND_SAVE;
      show = 1'b0;
    end else begin
      unique case (a_first)
        tcld_pkg::CMD_STATE: begin
          kind = (c_cnt >= CntW'(1)) ? tcld_pkg::KIND_STATE : tcld_pkg::KIND_IGNORED;
        end
        tcld_pkg::CMD_MIX: begin
          kind = (c_cnt >= CntW'(3)) ? tcld_pkg::KIND_MIX : tcld_pkg::KIND_IGNORED;
        end
        tcld_pkg::CMD_MANUAL: begin
          kind = (c_cnt >= CntW'(2)) ? tcld_pkg::KIND_MANUAL : tcld_pkg::KIND_IGNORED;
        end
        tcld_pkg::CMD_ZERO: begin
          kind = (c_cnt >= CntW'(1)) ? tcld_pkg::KIND_ZERO : tcld_pkg::KIND_IGNORED;
        end
        tcld_pkg::CMD_PARAM: begin
          kind = (c_cnt >= CntW'(2)) ? tcld_pkg::KIND_PARAM : tcld_pkg::KIND_IGNORED;
        end
        tcld_pkg::CMD_RESET: begin
          kind = tcld_pkg::KIND_RESET;
        end
        tcld_pkg::CMD_VISION: begin
          kind = (c_cnt >= CntW'(2)) ? tcld_pkg::KIND_VISION : tcld_pkg::KIND_IGNORED;
          if (c_cnt < CntW'(3)) begin
            args[2] = tcld_pkg::VISION_ARG2_DEFAULT;
          end
          if (c_cnt < CntW'(4)) begin
            args[3] = tcld_pkg::VISION_ARG3_DEFAULT;
          end
        end
        tcld_pkg::CMD_HEART: begin
          kind = tcld_pkg::KIND_HEART;
        end
        default: begin
          kind = tcld_pkg::KIND_IGNORED;
        end
      endcase
      if (kind == tcld_pkg::KIND_IGNORED) begin
        show = 1'b0;
      end
    end

    res_o.valid = req_i.en && closing && a_nonblank;
    res_o.kind  = kind;
    res_o.args  = show ? args : '0;
  end

  always_comb begin
    pos_d      = pos_q;
    first_d    = first_q;
    pm_d       = pm_q;
    args_en_d  = args_en_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    sat_d      = sat_q;
    cnt_d      = cnt_q;
    store_d    = store_q;
    nonblank_d = nonblank_q;
    if (req_i.en) begin
      if (closing) begin
        pos_d      = '0;
        first_d    = '0;
        pm_d       = 2'b11;
        args_en_d  = 1'b0;
        phase_d    = tcld_pkg::PH_BEFORE;
        neg_d      = 1'b0;
        acc_d      = '0;
        sat_d      = 1'b0;
        cnt_d      = '0;
        store_d    = '0;
        nonblank_d = 1'b0;
      end else begin
        pos_d      = a_pos;
        first_d    = a_first;
        pm_d       = a_pm;
        args_en_d  = a_args_en;
        phase_d    = a_phase;
        neg_d      = a_neg;
        acc_d      = a_acc;
        sat_d      = a_sat;
        cnt_d      = a_cnt;
        store_d    = a_store;
        nonblank_d = a_nonblank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      first_q    <= '0;
      pm_q       <= 2'b11;
      args_en_q  <= 1'b0;
      phase_q    <= tcld_pkg::PH_BEFORE;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      sat_q      <= 1'b0;
      cnt_q      <= '0;
      store_q    <= '0;
      nonblank_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      first_q    <= first_d;
      pm_q       <= pm_d;
      args_en_q  <= args_en_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      acc_q      <= acc_d;
      sat_q      <= sat_d;
      cnt_q      <= cnt_d;
      store_q    <= store_d;
      nonblank_q <= nonblank_d;
    end
  end

endmodule

@@ src/text_command_line_decoder_core.sv @@
// ----------------------------------------------------------------------------
// text_command_line_decoder_core
// Decodes newline-terminated ASCII command lines from received bytes and
// reports link health on millisecond ticks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ------------------------------
//   in       sink       in_valid_i/in_ready_o  cmd_i, data_byte_i, frame_end_i
//   out      source     out_valid_o/out_ready_i kind_o, arg0_o..arg3_o,
//                                              link_ok_o
//   cfg      APB slave  psel/penable/pready    timeout_ms at address 0
//
// One request per cycle is sustained while out_ready_i is high. A request is
// held in the input register, decoded there, and its result (if any) lands
// in the output register, which drives out_valid_o.
// The input register advances whenever the output register is empty or
// being read, so a stalled output backs up at most one extra request.
// Reset clears the line parser, the watchdog and restores timeout_ms to 500.
// ----------------------------------------------------------------------------
module text_command_line_decoder_core #(
  parameter int unsigned MAX_ARGS = 6,
  parameter int unsigned ARG_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_end_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         kind_o,
  output logic signed [31:0] arg0_o,
  output logic signed [31:0] arg1_o,
  output logic signed [31:0] arg2_o,
  output logic signed [31:0] arg3_o,
  output logic               link_ok_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned OW = tcld_pkg::OUT_W;

  logic                   in_vld_q, in_vld_d;
  logic                   cmd_q;
  logic [7:0]             byte_q;
  logic                   fe_q;

  logic                   out_vld_q, out_vld_d;
  tcld_pkg::kind_e        out_kind_q, out_kind_d;
  logic [3:0][OW-1:0]     out_args_q, out_args_d;
  logic                   out_link_q, out_link_d;

  logic [15:0]            timeout_q, timeout_d;
  logic                   dead_q, dead_d;
  logic [31:0]            elapsed_q, elapsed_d;
  logic                   heard_q, heard_d;

  logic                   accept, advance, is_byte;
  logic [tcld_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                   cfg_wr;
  tcld_pkg::line_req_t    line_req;
  tcld_pkg::line_res_t    line_res;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign is_byte    = !cmd_q;

  assign line_req.en = advance && is_byte && !dead_q;
  assign line_req.ch = byte_q;
  assign line_req.fe = fe_q;

  tcld_line #(
    .MAX_ARGS (MAX_ARGS),
    .ARG_BITS (ARG_BITS)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (line_req),
    .res_o  (line_res)
  );

  // Configuration port.
  assign cfg_idx = paddr[2 +: tcld_pkg::CFG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  always_comb begin
    prdata    = '0;
    timeout_d = timeout_q;
    if (cfg_idx == tcld_pkg::REG_TIMEOUT) begin
      prdata = {16'b0, timeout_q};
      if (cfg_wr) begin
        timeout_d = pwdata[15:0];
      end
    end
  end

  always_comb begin
    in_vld_d   = in_vld_q;
    out_vld_d  = out_vld_q;
    out_kind_d = out_kind_q;
    out_args_d = out_args_q;
    out_link_d = out_link_q;
    dead_d     = dead_q;
    elapsed_d  = elapsed_q;
    heard_d    = heard_q;

    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end

    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end

    if (advance) begin
      if (!is_byte) begin
        // Tick: count, then report the link health.
        if (elapsed_q != 32'hFFFF_FFFF) begin
          elapsed_d = elapsed_q + 32'd1;
        end
        out_vld_d  = 1'b1;
        out_kind_d = tcld_pkg::KIND_LINK;
        out_args_d = '0;
        out_link_d = !(heard_q && (elapsed_d > {16'b0, timeout_q}));
      end else if (dead_q) begin
        // Skip the rest of a frame after a zero byte.
        if (fe_q) begin
          dead_d = 1'b0;
        end
      end else begin
        if ((byte_q == tcld_pkg::CH_NUL) && !fe_q) begin
          dead_d = 1'b1;
        end
        if (line_res.valid) begin
          heard_d    = 1'b1;
          elapsed_d  = '0;
          out_vld_d  = 1'b1;
          out_kind_d = line_res.kind;
          out_args_d = line_res.args;
          out_link_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      byte_q <= data_byte_i;
      fe_q   <= frame_end_i;
    end
    out_kind_q <= out_kind_d;
    out_args_q <= out_args_d;
    out_link_q <= out_link_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      timeout_q <= tcld_pkg::TIMEOUT_RESET;
      dead_q    <= 1'b0;
      elapsed_q <= '0;
      heard_q   <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      timeout_q <= timeout_d;
      dead_q    <= dead_d;
      elapsed_q <= elapsed_d;
      heard_q   <= heard_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_kind_q;
  assign arg0_o      = signed'(out_args_q[0]);
  assign arg1_o      = signed'(out_args_q[1]);
  assign arg2_o      = signed'(out_args_q[2]);
  assign arg3_o      = signed'(out_args_q[3]);
  assign link_ok_o   = out_link_q;

endmodule
